FILE: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  // Ring geometry (DEPTH is a power of two so ring positions wrap for free)
  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 5;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK       = 3'd4
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input item, update pointers, access the ring
    logic load_out;  // register the finished result
  } cmd_t;

endpackage : bdq_pkg

`default_nettype wire

FILE: src/bounded_deque_with_eviction.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_eviction
// Double-ended queue of signed 32-bit values in a 16-slot ring, with
// eviction at the opposite end when a push finds the queue full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation: in_func
//   selects push front, push back, pop front, pop back or peek; in_value is
//   the pushed value and in_index the peek position from the front.
//   Result channel (out_valid / out_stall) returns one result per operation:
//   out_data, out_found, out_count and out_empty_res.
//   cfg_wr_en / cfg_wr_data set the capacity limit (0 means all 16 slots);
//   write it only while no operation is in flight.
// Timing:
//   An operation is accepted in the idle state, where pointers update and the
//   slot RAM is written or read; the result register loads in the exec state
//   once the output is free, and out_valid rises as it loads. A new operation
//   is not accepted before the result of the last one has been loaded.
//   The next operation is accepted while a result still waits at the output.
// Reset (rst_n low, synchronous) empties the queue and clears the limit;
//   slot contents are not cleared. While out_stall is high the result holds
//   and, once the following operation has been accepted, in_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_eviction (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic        [bdq_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [bdq_pkg::FUNC_W-1:0] in_func,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_value,
  input  wire logic        [bdq_pkg::IDX_W-1:0]  in_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [bdq_pkg::DATA_W-1:0] out_data,
  output logic                                   out_found,
  output logic             [bdq_pkg::CNT_W-1:0]  out_count,
  output logic                                   out_empty_res
);

  import bdq_pkg::*;

  cmd_t cmd;

  // Sequence each transfer
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Ring storage and result
  bdq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_index      (in_index),
    .out_data      (out_data),
    .out_found     (out_found),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

endmodule : bounded_deque_with_eviction

`default_nettype wire

FILE: src/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule : bdq_ram

`default_nettype wire

FILE: src/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: sequences each item through accept and result stages and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bdq_pkg::cmd_t      cmd
);

  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Issue commands
  always_comb begin
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.load_out = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  end

  // Advance the state machine
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until the receiver takes the transfer
  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule : bdq_ctrl

`default_nettype wire

FILE: src/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring pointers, fill count, capacity register, slot RAM and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bdq_pkg::cmd_t                     cmd,
  input  wire logic                              cfg_wr_en,
  input  wire logic        [bdq_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic        [bdq_pkg::FUNC_W-1:0] in_func,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_value,
  input  wire logic        [bdq_pkg::IDX_W-1:0]  in_index,
  output logic signed      [bdq_pkg::DATA_W-1:0] out_data,
  output logic                                   out_found,
  output logic             [bdq_pkg::CNT_W-1:0]  out_count,
  output logic                                   out_empty_res
);

  import bdq_pkg::*;

  logic [CFG_W-1:0]  max_entries_r;
  logic [PTR_W-1:0]  front_r;
  logic [PTR_W-1:0]  front_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  limit;
  logic              full;
  logic [PTR_W-1:0]  fill_lo;
  logic              hit;
  logic              hit_r;
  logic [CNT_W-1:0]  count_r;
  logic              ram_wr_en;
  logic [PTR_W-1:0]  ram_wr_addr;
  logic              ram_rd_en;
  logic [PTR_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic [DATA_W-1:0] out_data_r;
  logic              out_found_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_r;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= '0;
    end else if (cfg_wr_en) begin
      max_entries_r <= cfg_wr_data;
    end
  end

  // Effective limit: zero or anything above the ring size means the full ring
  always_comb begin
    if ((max_entries_r == '0) || (CNT_W'(max_entries_r) > CNT_W'(DEPTH))) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(max_entries_r);
    end
  end

  assign full    = (fill_r >= limit);
  assign fill_lo = fill_r[PTR_W-1:0];

  // Decode the operation into pointer updates and ring accesses
  always_comb begin
    front_nxt   = front_r;
    fill_nxt    = fill_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = front_r;
    ram_rd_addr = front_r;
    hit         = 1'b0;
    unique case (in_func)
      FN_PUSH_FRONT: begin
        // a full queue drops its back element, so the count holds
        front_nxt   = front_r - PTR_W'(1);
        ram_wr_en   = 1'b1;
        ram_wr_addr = front_r - PTR_W'(1);
        if (!full) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      FN_PUSH_BACK: begin
        // slot past the back is the same whether or not the front is dropped
        ram_wr_en   = 1'b1;
        ram_wr_addr = front_r + fill_lo;
        if (full) begin
          front_nxt = front_r + PTR_W'(1);
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      FN_POP_FRONT: begin
        if (fill_r != '0) begin
          hit         = 1'b1;
          ram_rd_addr = front_r;
          front_nxt   = front_r + PTR_W'(1);
          fill_nxt    = fill_r - CNT_W'(1);
        end
      end
      FN_POP_BACK: begin
        if (fill_r != '0) begin
          hit         = 1'b1;
          ram_rd_addr = front_r + fill_lo - PTR_W'(1);
          fill_nxt    = fill_r - CNT_W'(1);
        end
      end
      FN_PEEK: begin
        if (CNT_W'(in_index) < fill_r) begin
          hit         = 1'b1;
          ram_rd_addr = front_r + PTR_W'(in_index);
        end
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  assign ram_rd_en = cmd.accept && hit;

  // Advance ring pointers on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      fill_r  <= '0;
    end else if (cmd.accept) begin
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Hold result status until the read data returns
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hit_r   <= hit;
      count_r <= fill_nxt;
    end
  end

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.accept && ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r  <= hit_r ? ram_rd_data : '0;
      out_found_r <= hit_r;
      out_count_r <= count_r;
      out_empty_r <= (count_r == '0);
    end
  end

  assign out_data      = out_data_r;
  assign out_found     = out_found_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;

endmodule : bdq_dp

`default_nettype wire

FILE: src/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the result channel of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [bdq_pkg::DATA_W-1:0] out_data,
  input wire logic                              out_found,
  input wire logic        [bdq_pkg::CNT_W-1:0]  out_count,
  input wire logic                              out_empty_res
);

  import bdq_pkg::*;

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A miss carries zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_data == '0)
    else $error("nonzero data on a miss");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // Count never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count beyond ring size");

endmodule : bdq_checker

bind bounded_deque_with_eviction bdq_checker u_bdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_data      (out_data),
  .out_found     (out_found),
  .out_count     (out_count),
  .out_empty_res (out_empty_res)
);

`default_nettype wire
